// ===== hw/rtl/stereo_biquad_filter_core_macros.svh =====
// Assertion macros shared by the stereo biquad filter checkers.
// Each macro expands to one labeled concurrent assertion with reset disable.
`ifndef STEREO_BIQUAD_FILTER_CORE_MACROS_SVH
`define STEREO_BIQUAD_FILTER_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SBQF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("sbqf assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SBQF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("sbqf assertion failed");

`endif

// ===== hw/rtl/sbqf_pkg.sv =====
// Package for the stereo biquad filter: widths, register indexes and the coefficient set.
// No dependencies.
`timescale 1ns / 1ps

package sbqf_pkg;

	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int COEF_BITS          = 20;
	localparam int NUM_COEFS          = 5;
	localparam int CFG_IDX_BITS       = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_B0,
		CFG_B1,
		CFG_B2,
		CFG_A1,
		CFG_A2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] b0;
		logic signed [COEF_BITS-1:0] b1;
		logic signed [COEF_BITS-1:0] b2;
		logic signed [COEF_BITS-1:0] a1;
		logic signed [COEF_BITS-1:0] a2;
	} coef_set_t;

endpackage

// ===== hw/rtl/sbqf_if.sv =====
// Valid/ready stream interfaces for filter samples in and out.
// Depends on sbqf_pkg for the default sample width.
`timescale 1ns / 1ps

interface sbqf_in_if #(
	parameter int SAMPLE_BITS = sbqf_pkg::SAMPLE_BITS_DEF
);
	import sbqf_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          channel;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output channel, output sample_in, input ready);
	modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface sbqf_out_if #(
	parameter int SAMPLE_BITS = sbqf_pkg::SAMPLE_BITS_DEF
);
	import sbqf_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          channel_out;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output channel_out, output sample_out, input ready);
	modport sink   (input valid, input channel_out, input sample_out, output ready);
endinterface

// ===== hw/rtl/stereo_biquad_filter_core.sv =====
// Top level of the two-channel direct form I biquad filter.
// Depends on sbqf_pkg, the sbqf_in_if and sbqf_out_if interfaces and sbqf_mac.
//
// Usage: samples enter on din (valid/ready), tagged with a channel bit, and
// each accepted transaction produces exactly one filtered transaction on dout,
// in order. Coefficients are written through cfg_we, cfg_idx and cfg_wdata
// while the filter is idle; indexes above the last coefficient are ignored.
// An accepted sample passes the s1, s2 and s3 stages and the output register
// before dout.valid. A sample of the other channel can be taken while one is
// in flight, but a sample of the same channel as one still in the three
// multiply/accumulate stages waits, since it needs that sample's output as
// history. This wait is set by the read of the history memory, the product
// stage and the sum stage that close the feedback loop. The history of both
// channels lives in a two-entry memory of one row per channel, read into a
// register as each sample is accepted and written back from the last stage.
// Reset clears the history of both channels through per-row valid bits and
// loads the coefficients with a unity pass-through. When dout is stalled the
// whole pipeline holds and din.ready falls until the output is taken.
`timescale 1ns / 1ps

module stereo_biquad_filter_core #(
	parameter int SAMPLE_BITS    = sbqf_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = sbqf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	sbqf_in_if.sink                               din,
	sbqf_out_if.source                            dout,
	input  logic                                  cfg_we,
	input  logic [sbqf_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
	input  logic [sbqf_pkg::COEF_BITS-1:0]        cfg_wdata
);
	import sbqf_pkg::*;

	localparam int ROW_W = 4 * SAMPLE_BITS;
	localparam logic signed [COEF_BITS-1:0] B0_RESET = COEF_BITS'(longint'(1) << COEF_FRAC_BITS);

	coef_set_t coef_q;

	logic [ROW_W-1:0] hist_mem [2];
	logic [1:0]       hist_valid_q;

	logic                          adv;
	logic                          hazard;
	logic                          accept;

	logic                          v_s1, v_s2, v_s3;
	logic                          ch_s1, ch_s2, ch_s3;
	logic                          rdv_s1;
	logic [ROW_W-1:0]              rd_s1;
	logic [ROW_W-1:0]              row_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1, x_s2, x_s3;
	logic signed [SAMPLE_BITS-1:0] x1_s1, x2_s1, y1_s1, y2_s1;
	logic signed [SAMPLE_BITS-1:0] x1_s2, x1_s3, y1_s2, y1_s3;
	logic signed [SAMPLE_BITS-1:0] y_s3;

	logic                          out_valid_q;
	logic                          out_ch_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= B0_RESET;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_B0:  coef_q.b0 <= cfg_wdata;
				CFG_B1:  coef_q.b1 <= cfg_wdata;
				CFG_B2:  coef_q.b2 <= cfg_wdata;
				CFG_A1:  coef_q.a1 <= cfg_wdata;
				CFG_A2:  coef_q.a2 <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign adv    = !out_valid_q || dout.ready;
	assign hazard = (v_s1 && (ch_s1 == din.channel)) || (v_s2 && (ch_s2 == din.channel))
		|| (v_s3 && (ch_s3 == din.channel));
	assign din.ready = adv && !hazard;
	assign accept    = din.valid && din.ready;

	// Rows are laid out as {y2, y1, x2, x1}.
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= hist_mem[din.channel];
		end
		if (adv && v_s3) begin
			hist_mem[ch_s3] <= {y1_s3, y_s3, x1_s3, x_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q <= '0;
			rdv_s1       <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			rdv_s1      <= hist_valid_q[din.channel];
			v_s1        <= accept;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
			if (v_s3) begin
				hist_valid_q[ch_s3] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1        <= din.channel;
			x_s1         <= din.sample_in;
			ch_s2        <= ch_s1;
			x_s2         <= x_s1;
			x1_s2        <= x1_s1;
			y1_s2        <= y1_s1;
			ch_s3        <= ch_s2;
			x_s3         <= x_s2;
			x1_s3        <= x1_s2;
			y1_s3        <= y1_s2;
			out_ch_q     <= ch_s3;
			out_sample_q <= y_s3;
		end
	end

	assign row_s1 = rdv_s1 ? rd_s1 : '0;
	assign x1_s1  = row_s1[SAMPLE_BITS-1:0];
	assign x2_s1  = row_s1[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign y1_s1  = row_s1[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
	assign y2_s1  = row_s1[4*SAMPLE_BITS-1:3*SAMPLE_BITS];

	sbqf_mac #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk   (clk),
		.en    (adv),
		.coefs (coef_q),
		.x_s1  (x_s1),
		.x1_s1 (x1_s1),
		.x2_s1 (x2_s1),
		.y1_s1 (y1_s1),
		.y2_s1 (y2_s1),
		.y_s3  (y_s3)
	);

	assign dout.valid       = out_valid_q;
	assign dout.channel_out = out_ch_q;
	assign dout.sample_out  = out_sample_q;

endmodule

// ===== hw/rtl/sbqf_mac.sv =====
// Multiply-accumulate pipeline of the biquad: five products, one sum, rounding and saturation.
// Depends on sbqf_pkg for the coefficient set.
`timescale 1ns / 1ps

module sbqf_mac #(
	parameter int SAMPLE_BITS    = sbqf_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = sbqf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  sbqf_pkg::coef_set_t           coefs,
	input  logic signed [SAMPLE_BITS-1:0] x_s1,
	input  logic signed [SAMPLE_BITS-1:0] x1_s1,
	input  logic signed [SAMPLE_BITS-1:0] x2_s1,
	input  logic signed [SAMPLE_BITS-1:0] y1_s1,
	input  logic signed [SAMPLE_BITS-1:0] y2_s1,
	output logic signed [SAMPLE_BITS-1:0] y_s3
);
	import sbqf_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W  = PROD_W + 3;
	localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(longint'(1) << (COEF_FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-(longint'(1) << (SAMPLE_BITS - 1)));

	logic signed [PROD_W-1:0] pb0_s2, pb1_s2, pb2_s2, pa1_s2, pa2_s2;
	logic signed [ACC_W-1:0]  acc_s3;
	logic signed [ACC_W-1:0]  shifted;

	always_ff @(posedge clk) begin
		if (en) begin
			pb0_s2 <= PROD_W'(x_s1) * PROD_W'(coefs.b0);
			pb1_s2 <= PROD_W'(x1_s1) * PROD_W'(coefs.b1);
			pb2_s2 <= PROD_W'(x2_s1) * PROD_W'(coefs.b2);
			pa1_s2 <= PROD_W'(y1_s1) * PROD_W'(coefs.a1);
			pa2_s2 <= PROD_W'(y2_s1) * PROD_W'(coefs.a2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s3 <= ACC_W'(pb0_s2) + ACC_W'(pb1_s2) + ACC_W'(pb2_s2)
				- ACC_W'(pa1_s2) - ACC_W'(pa2_s2) + HALF;
		end
	end

	// The rounding offset is already in the sum, so an arithmetic shift gives round to nearest.
	assign shifted = acc_s3 >>> COEF_FRAC_BITS;

	always_comb begin
		if (shifted > SAT_MAX) begin
			y_s3 = SAT_MAX[SAMPLE_BITS-1:0];
		end else if (shifted < SAT_MIN) begin
			y_s3 = SAT_MIN[SAMPLE_BITS-1:0];
		end else begin
			y_s3 = shifted[SAMPLE_BITS-1:0];
		end
	end

endmodule

// ===== hw/rtl/sbqf_checker.sv =====
// Port-level checker for the stereo biquad filter core, with its bind statement.
// Depends on sbqf_pkg and stereo_biquad_filter_core_macros.svh.
`timescale 1ns / 1ps
`include "stereo_biquad_filter_core_macros.svh"

module sbqf_checker #(
	parameter int SAMPLE_BITS = sbqf_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   in_channel,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   out_channel,
	input logic [SAMPLE_BITS-1:0] out_sample
);
	import sbqf_pkg::*;

	localparam logic [2:0] MAX_PENDING = 3'd4;

	logic       in_acc;
	logic       out_acc;
	logic [2:0] pend_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Transactions accepted on the input and not yet delivered on the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 3'd1;
		end else if (!in_acc && out_acc) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	`SBQF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_sample) && $stable(out_channel))
	`SBQF_ASSERT_NEXT(a_same_channel_spacing, clk, arst_n, in_acc,
		!(in_acc && (in_channel == $past(in_channel))))
	`SBQF_ASSERT_NOW(a_pending_bound, clk, arst_n, 1'b1, pend_q <= MAX_PENDING)
	`SBQF_ASSERT_NOW(a_no_spurious_out, clk, arst_n, out_valid, pend_q != 3'd0)

endmodule

bind stereo_biquad_filter_core sbqf_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_sbqf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (din.valid),
	.in_ready    (din.ready),
	.in_channel  (din.channel),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.out_channel (dout.channel_out),
	.out_sample  (dout.sample_out)
);
